### rtl/core/fxau_pkg.sv
// Shared types and constants for the Q16.16 fixed-point arithmetic unit.
`default_nettype none
package fxau_pkg;

  localparam logic [2:0] CMD_MUL   = 3'd0;
  localparam logic [2:0] CMD_DIV   = 3'd1;
  localparam logic [2:0] CMD_ROUND = 3'd2;
  localparam logic [2:0] CMD_FLOOR = 3'd3;
  localparam logic [2:0] CMD_DOT   = 3'd4;
  localparam logic [2:0] CMD_PROJ  = 3'd5;

  localparam logic [1:0] REG_X_SCALE  = 2'd0;
  localparam logic [1:0] REG_Y_SCALE  = 2'd1;
  localparam logic [1:0] REG_X_OFFSET = 2'd2;
  localparam logic [1:0] REG_Y_OFFSET = 2'd3;

  localparam logic [31:0] SAT_POS   = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG   = 32'h8000_0001;
  localparam logic [14:0] LIMIT_INT = 15'd32767;
  localparam logic [62:0] MUL_LIMIT = {16'd0, LIMIT_INT, 32'd0};

  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } fxau_in_t;

  typedef struct packed {
    logic signed [31:0] result_main;
    logic signed [31:0] result_extra;
    logic               range_error;
  } fxau_out_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] num;
    logic [31:0] den;
    logic        neg;
    logic        sat;
  } fxau_div_t;

endpackage
`default_nettype wire

### rtl/core/fixed_point_16_16_arith_unit.sv
// Top level of the pipelined Q16.16 fixed-point arithmetic unit.
// Every request is accepted (busy stays low) and its result appears on out_data with
// out_valid at the end of the pipeline, one result per cycle at full rate.
// Most of the pipeline is the restoring divider, which resolves one quotient bit per stage
// over 32 stages, then quotient rounding, multiply, magnitude, round/saturate and sum.
`default_nettype none
module fixed_point_16_16_arith_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire fxau_pkg::fxau_in_t in_data,
  output logic                   out_valid,
  output fxau_pkg::fxau_out_t    out_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_idx,
  input  wire logic [31:0]       cfg_data
);

  localparam int DV_LAST = fxau_pkg::DIV_STEPS;
  localparam int ST_Q    = DV_LAST + 2;
  localparam int ST_P    = ST_Q + 1;
  localparam int ST_M    = ST_P + 1;
  localparam int ST_V    = ST_M + 1;
  localparam int NST     = ST_V + 1;

  logic [31:0] x_scale_r, y_scale_r, x_off_r, y_off_r;

  logic               vld_r [0:NST-1];
  fxau_pkg::fxau_in_t itm_r [0:NST-1];
  fxau_pkg::fxau_div_t dv0_r [0:DV_LAST];
  fxau_pkg::fxau_div_t dv1_r [0:DV_LAST];

  logic signed [31:0] q0_r, q1_r;
  logic signed [31:0] q0_p_r, q0_m_r;
  logic               qerr_r;
  logic signed [63:0] p_r [0:2];
  logic               perr_r;
  logic [62:0]        m_r [0:2];
  logic [2:0]         mneg_r;
  logic               merr_r;
  logic [31:0]        v_r [0:2];
  logic               verr_r;

  logic                out_valid_r;
  fxau_pkg::fxau_out_t out_r, out_nxt;

  fxau_pkg::fxau_div_t front0, front1;
  fxau_pkg::fxau_div_t step0 [1:DV_LAST];
  fxau_pkg::fxau_div_t step1 [1:DV_LAST];
  logic signed [31:0] q0_nxt, q1_nxt;
  logic signed [31:0] ma [0:2];
  logic signed [31:0] mb [0:2];
  logic [31:0]        v_nxt [0:2];
  logic [2:0]         vsat;

  assign busy = 1'b0;

  function automatic fxau_pkg::fxau_div_t div_front(logic [31:0] x, logic [31:0] y);
    fxau_pkg::fxau_div_t d;
    logic [31:0] mx, my;
    logic [46:0] lim;
    mx = x[31] ? 32'(-x) : x;
    my = y[31] ? 32'(-y) : y;
    lim = 47'(my) * 47'(fxau_pkg::LIMIT_INT);
    d.rem = {16'd0, mx[31:15]};
    d.num = {mx[14:0], 17'd0};
    d.den = my;
    if (y == 32'd0) begin
      d.sat = 1'b1;
      d.neg = x[31];
    end else begin
      d.sat = {15'd0, mx} > lim;
      d.neg = x[31] ^ y[31];
    end
    return d;
  endfunction

  function automatic fxau_pkg::fxau_div_t div_step(fxau_pkg::fxau_div_t d);
    fxau_pkg::fxau_div_t o;
    logic [32:0] r2;
    o = d;
    r2 = {d.rem[31:0], d.num[31]};
    if (r2 >= {1'b0, d.den}) begin
      o.rem = r2 - {1'b0, d.den};
      o.num = {d.num[30:0], 1'b1};
    end else begin
      o.rem = r2;
      o.num = {d.num[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic signed [31:0] div_final(fxau_pkg::fxau_div_t d);
    logic [32:0] qr;
    logic [31:0] q;
    qr = {1'b0, d.num} + 33'd1;
    q = qr[32:1];
    if (d.sat) begin
      return d.neg ? fxau_pkg::SAT_NEG : fxau_pkg::SAT_POS;
    end
    return d.neg ? 32'(-q) : q;
  endfunction

  always_comb begin
    if (itm_r[0].command == fxau_pkg::CMD_DIV) begin
      front0 = div_front(itm_r[0].a_x, itm_r[0].a_y);
    end else begin
      front0 = div_front(itm_r[0].a_x, itm_r[0].a_z);
    end
    front1 = div_front(itm_r[0].a_y, itm_r[0].a_z);
    for (int k = 1; k <= DV_LAST; k++) begin
      step0[k] = div_step(dv0_r[k-1]);
      step1[k] = div_step(dv1_r[k-1]);
    end
    q0_nxt = div_final(dv0_r[DV_LAST]);
    q1_nxt = div_final(dv1_r[DV_LAST]);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (itm_r[ST_Q].command)
      fxau_pkg::CMD_MUL: begin
        ma[0] = itm_r[ST_Q].a_x;
        mb[0] = itm_r[ST_Q].a_y;
      end
      fxau_pkg::CMD_DOT: begin
        ma[0] = itm_r[ST_Q].a_x;
        mb[0] = itm_r[ST_Q].b_x;
        ma[1] = itm_r[ST_Q].a_y;
        mb[1] = itm_r[ST_Q].b_y;
        ma[2] = itm_r[ST_Q].a_z;
        mb[2] = itm_r[ST_Q].b_z;
      end
      fxau_pkg::CMD_PROJ: begin
        ma[0] = q0_r;
        mb[0] = x_scale_r;
        ma[1] = q1_r;
        mb[1] = y_scale_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    logic [62:0] rs;
    for (int i = 0; i < 3; i++) begin
      rs = m_r[i] + 63'h8000;
      vsat[i] = m_r[i] > fxau_pkg::MUL_LIMIT;
      if (vsat[i]) begin
        v_nxt[i] = mneg_r[i] ? fxau_pkg::SAT_NEG : fxau_pkg::SAT_POS;
      end else begin
        v_nxt[i] = mneg_r[i] ? 32'(-rs[47:16]) : rs[47:16];
      end
    end
  end

  always_comb begin
    logic [31:0] fl;
    fl = {{16{itm_r[ST_V].a_x[31]}}, itm_r[ST_V].a_x[31:16]};
    out_nxt = '0;
    case (itm_r[ST_V].command)
      fxau_pkg::CMD_MUL: begin
        out_nxt.result_main = v_r[0];
        out_nxt.range_error = verr_r;
      end
      fxau_pkg::CMD_DIV: begin
        out_nxt.result_main = v_r[0];
        out_nxt.range_error = verr_r;
      end
      fxau_pkg::CMD_ROUND: begin
        out_nxt.result_main = fl + {31'd0, itm_r[ST_V].a_x[15]};
      end
      fxau_pkg::CMD_FLOOR: begin
        out_nxt.result_main = fl;
      end
      fxau_pkg::CMD_DOT: begin
        out_nxt.result_main = v_r[0] + v_r[1] + v_r[2];
        out_nxt.range_error = verr_r;
      end
      fxau_pkg::CMD_PROJ: begin
        out_nxt.result_main  = v_r[0] + x_off_r;
        out_nxt.result_extra = v_r[1] + y_off_r;
        out_nxt.range_error  = verr_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_scale_r <= 32'h0001_0000;
      y_scale_r <= 32'h0001_0000;
      x_off_r   <= '0;
      y_off_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        fxau_pkg::REG_X_SCALE:  x_scale_r <= cfg_data;
        fxau_pkg::REG_Y_SCALE:  y_scale_r <= cfg_data;
        fxau_pkg::REG_X_OFFSET: x_off_r   <= cfg_data;
        fxau_pkg::REG_Y_OFFSET: y_off_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= start && !busy;
      for (int k = 1; k < NST; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[ST_V];
    end
  end

  always_ff @(posedge clk) begin
    itm_r[0] <= in_data;
    for (int k = 1; k < NST; k++) begin
      itm_r[k] <= itm_r[k-1];
    end
    dv0_r[0] <= front0;
    dv1_r[0] <= front1;
    for (int k = 1; k <= DV_LAST; k++) begin
      dv0_r[k] <= step0[k];
      dv1_r[k] <= step1[k];
    end
    q0_r   <= q0_nxt;
    q1_r   <= q1_nxt;
    qerr_r <= (itm_r[DV_LAST+1].command == fxau_pkg::CMD_DIV && dv0_r[DV_LAST].sat)
           || (itm_r[DV_LAST+1].command == fxau_pkg::CMD_PROJ
               && (dv0_r[DV_LAST].sat || dv1_r[DV_LAST].sat));
    for (int i = 0; i < 3; i++) begin
      p_r[i]    <= ma[i] * mb[i];
      mneg_r[i] <= p_r[i][63];
      m_r[i]    <= p_r[i][63] ? 63'(-p_r[i]) : p_r[i][62:0];
      v_r[i]    <= (itm_r[ST_M].command == fxau_pkg::CMD_DIV && i == 0) ? q0_m_r : v_nxt[i];
    end
    perr_r <= qerr_r;
    merr_r <= perr_r;
    verr_r <= merr_r || (itm_r[ST_M].command != fxau_pkg::CMD_DIV && (|vsat));
    out_r  <= out_nxt;
  end

  // The divide result bypasses the multiplier stages alongside the products.
  always_ff @(posedge clk) begin
    q0_p_r <= q0_r;
    q0_m_r <= q0_p_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### rtl/core/fxau_checker.sv
// Port-level checker for the Q16.16 arithmetic unit, bound to the top level.
`default_nettype none
module fxau_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire fxau_pkg::fxau_in_t  in_data,
  input wire logic                out_valid,
  input wire fxau_pkg::fxau_out_t out_data
);

  localparam int LAT = 39;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy was raised");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a matching request");

  a_extra_only_proj: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_data.command, LAT) != fxau_pkg::CMD_PROJ)
      |-> out_data.result_extra == 32'd0)
    else $error("extra result set for a command other than projection");

  a_no_err_on_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_data.command, LAT) == fxau_pkg::CMD_ROUND
      || $past(in_data.command, LAT) == fxau_pkg::CMD_FLOOR))
      |-> !out_data.range_error)
    else $error("range error on an integer conversion");

endmodule

bind fixed_point_16_16_arith_unit fxau_checker u_fxau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
